/* rtl/dcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dcd_pkg;

  localparam int CodeW   = 16;
  localparam int DutyW   = 10;
  localparam int PctW    = 7;
  localparam int TensW   = 7;
  localparam int DimW    = 8;
  localparam int BridgeW = 4;

  // base speed is always a whole number of tens of duty counts
  localparam int ProdW   = TensW + PctW;
  localparam int RecipW  = 13;
  localparam int RecipSh = 16;
  localparam int WideW   = ProdW + RecipW;

  localparam logic [RecipW-1:0] RecipTen  = 13'd6554;
  localparam logic [DutyW-1:0]  SpeedStep = 10'd10;
  localparam logic [DimW:0]     DimStep   = 9'd3;

  localparam logic [TensW-1:0] TensFull  = 7'd99;
  localparam logic [DutyW-1:0] FullSpeed = 10'd990;
  localparam logic [PctW-1:0]  PctFull   = 7'd100;
  localparam logic [DimW-1:0]  DimReset  = 8'd250;

  localparam logic [CodeW-1:0] CodeLeftLo  = 16'd1001;
  localparam logic [CodeW-1:0] CodeLeftHi  = 16'd1100;
  localparam logic [CodeW-1:0] CodeRightLo = 16'd1101;
  localparam logic [CodeW-1:0] CodeRightHi = 16'd1200;
  localparam logic [CodeW-1:0] CodeDimLo   = 16'd1205;
  localparam logic [CodeW-1:0] CodeDimHi   = 16'd1284;
  localparam logic [CodeW-1:0] CodeSpeedLo = 16'd1550;
  localparam logic [CodeW-1:0] CodeSpeedHi = 16'd1599;

  localparam logic [CodeW-1:0] LeftBase  = 16'd1000;
  localparam logic [CodeW-1:0] RightBase = 16'd1200;
  localparam logic [CodeW-1:0] DimBase   = 16'd1200;
  localparam logic [CodeW-1:0] SpeedBase = 16'd1500;

  localparam logic [CodeW-1:0] CodeStop      = 16'd2000;
  localparam logic [CodeW-1:0] CodeForward   = 16'd2001;
  localparam logic [CodeW-1:0] CodeBack      = 16'd2002;
  localparam logic [CodeW-1:0] CodeLeftRot   = 16'd2003;
  localparam logic [CodeW-1:0] CodeRightRot  = 16'd2004;
  localparam logic [CodeW-1:0] CodeStraight  = 16'd3000;
  localparam logic [CodeW-1:0] CodeFullSpeed = 16'd3001;
  localparam logic [CodeW-1:0] CodeBuzzOff   = 16'd4000;
  localparam logic [CodeW-1:0] CodeBuzzOn    = 16'd4001;
  localparam logic [CodeW-1:0] CodeLampOff   = 16'd5000;
  localparam logic [CodeW-1:0] CodeLampOn    = 16'd5001;
  localparam logic [CodeW-1:0] CodeDimOff    = 16'd6000;
  localparam logic [CodeW-1:0] CodeDimOn     = 16'd6001;

  typedef enum logic [BridgeW-1:0] {
    BridgeStop    = 4'd0,
    BridgeForward = 4'd5,
    BridgeLeft    = 4'd6,
    BridgeRight   = 4'd9,
    BridgeBack    = 4'd10
  } bridge_t;

endpackage

`default_nettype wire

/* rtl/drive_command_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-motor drive command decoder. Each command code transferred in produces
// exactly one result carrying the full drive and indicator state after that
// command; unrecognised codes leave the state as it was and still produce a
// result. A command waits in the input register until its result can be
// written to the output register, so a new command is taken every cycle
// while results are drained; the steering scale is one small multiply and a
// reciprocal divide by ten, both combinational.

module drive_command_decoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [dcd_pkg::CodeW-1:0]     command_code,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [dcd_pkg::DutyW-1:0]     duty_a,
  output logic      [dcd_pkg::DutyW-1:0]     duty_b,
  output logic      [dcd_pkg::BridgeW-1:0]   bridge_bits,
  output logic                               motor_enable,
  output logic      [dcd_pkg::DimW-1:0]      dim_duty,
  output logic                               dim_enable,
  output logic                               buzzer_on,
  output logic                               lamp_on
);
  import dcd_pkg::*;

  logic             stage_valid;
  logic [CodeW-1:0] code;
  logic             advance;
  logic             accept_in;

  logic [TensW-1:0] speed_tens, speed_tens_next;
  logic [PctW-1:0]  left_pct, left_pct_next;
  logic [PctW-1:0]  right_pct, right_pct_next;
  logic [DutyW-1:0] duty_a_next, duty_b_next;
  bridge_t          bridge, bridge_next;
  logic             motor_enable_next;
  logic [DimW-1:0]  dim_duty_next;
  logic             dim_enable_next, buzzer_on_next, lamp_on_next;

  logic [TensW-1:0] cmd_tens, sel_tens;
  logic [PctW-1:0]  cmd_left, cmd_right, sel_pct, dim_offset;
  logic [DutyW-1:0] speed, cmd_speed, scaled;
  logic [DimW-1:0]  cmd_dim;

  assign advance   = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !advance;
  assign accept_in = in_valid && !in_stall;

  assign cmd_tens   = TensW'(code - SpeedBase);
  assign cmd_left   = PctW'(code - LeftBase);
  assign cmd_right  = PctW'(RightBase - code);
  assign dim_offset = PctW'(code - DimBase);
  assign cmd_dim    = DimW'((DimW + 1)'(dim_offset) * DimStep);
  assign speed      = DutyW'(speed_tens) * SpeedStep;
  assign cmd_speed  = DutyW'(cmd_tens) * SpeedStep;

  always_comb begin
    sel_tens = speed_tens;
    sel_pct  = left_pct;
    if (code inside {[CodeLeftLo:CodeLeftHi]}) begin
      sel_pct = cmd_left;
    end else if (code inside {[CodeRightLo:CodeRightHi]}) begin
      sel_pct = cmd_right;
    end else if (code inside {[CodeSpeedLo:CodeSpeedHi]}) begin
      sel_tens = cmd_tens;
      sel_pct  = (duty_a > duty_b) ? left_pct : right_pct;
    end
  end

  dcd_scale u_scale (
    .speed_tens (sel_tens),
    .pct        (sel_pct),
    .duty       (scaled)
  );

  always_comb begin
    speed_tens_next   = speed_tens;
    left_pct_next     = left_pct;
    right_pct_next    = right_pct;
    duty_a_next       = duty_a;
    duty_b_next       = duty_b;
    bridge_next       = bridge;
    motor_enable_next = motor_enable;
    dim_duty_next     = dim_duty;
    dim_enable_next   = dim_enable;
    buzzer_on_next    = buzzer_on;
    lamp_on_next      = lamp_on;
    if (code inside {[CodeLeftLo:CodeLeftHi]}) begin
      left_pct_next = cmd_left;
      duty_a_next   = speed;
      duty_b_next   = scaled;
    end else if (code inside {[CodeRightLo:CodeRightHi]}) begin
      right_pct_next = cmd_right;
      duty_b_next    = speed;
      duty_a_next    = scaled;
    end else if (code inside {[CodeDimLo:CodeDimHi]}) begin
      dim_duty_next = cmd_dim;
    end else if (code inside {[CodeSpeedLo:CodeSpeedHi]}) begin
      speed_tens_next = cmd_tens;
      if (duty_a > duty_b) begin
        duty_a_next = cmd_speed;
        duty_b_next = scaled;
      end else if (duty_b > duty_a) begin
        duty_b_next = cmd_speed;
        duty_a_next = scaled;
      end else begin
        duty_a_next = cmd_speed;
        duty_b_next = cmd_speed;
      end
    end else begin
      case (code)
        CodeStop: begin
          bridge_next       = BridgeStop;
          motor_enable_next = 1'b0;
        end
        CodeForward: begin
          bridge_next       = BridgeForward;
          motor_enable_next = 1'b1;
        end
        CodeBack: begin
          bridge_next       = BridgeBack;
          motor_enable_next = 1'b1;
        end
        CodeLeftRot: begin
          bridge_next       = BridgeLeft;
          motor_enable_next = 1'b1;
        end
        CodeRightRot: begin
          bridge_next       = BridgeRight;
          motor_enable_next = 1'b1;
        end
        CodeStraight: begin
          duty_a_next    = speed;
          duty_b_next    = speed;
          left_pct_next  = PctFull;
          right_pct_next = PctFull;
        end
        CodeFullSpeed: begin
          speed_tens_next = TensFull;
          duty_a_next     = FullSpeed;
          duty_b_next     = FullSpeed;
          left_pct_next   = PctFull;
          right_pct_next  = PctFull;
        end
        CodeBuzzOff: buzzer_on_next  = 1'b0;
        CodeBuzzOn:  buzzer_on_next  = 1'b1;
        CodeLampOff: lamp_on_next    = 1'b0;
        CodeLampOn:  lamp_on_next    = 1'b1;
        CodeDimOff:  dim_enable_next = 1'b0;
        CodeDimOn:   dim_enable_next = 1'b1;
        default: ;
      endcase
    end
  end

  // load the command on transfer in
  always_ff @(posedge clk) begin
    if (accept_in) begin
      code <= command_code;
    end
  end

  // drive state doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      out_valid    <= 1'b0;
      speed_tens   <= TensFull;
      left_pct     <= PctFull;
      right_pct    <= PctFull;
      duty_a       <= FullSpeed;
      duty_b       <= FullSpeed;
      bridge       <= BridgeStop;
      motor_enable <= 1'b0;
      dim_duty     <= DimReset;
      dim_enable   <= 1'b0;
      buzzer_on    <= 1'b0;
      lamp_on      <= 1'b0;
    end else begin
      stage_valid <= accept_in || (stage_valid && !advance);
      out_valid   <= advance || (out_valid && out_stall);
      if (advance) begin
        speed_tens   <= speed_tens_next;
        left_pct     <= left_pct_next;
        right_pct    <= right_pct_next;
        duty_a       <= duty_a_next;
        duty_b       <= duty_b_next;
        bridge       <= bridge_next;
        motor_enable <= motor_enable_next;
        dim_duty     <= dim_duty_next;
        dim_enable   <= dim_enable_next;
        buzzer_on    <= buzzer_on_next;
        lamp_on      <= lamp_on_next;
      end
    end
  end

  assign bridge_bits = bridge;

`ifndef SYNTHESIS
  a_duty_limit: assert property (@(posedge clk) disable iff (rst)
    duty_a <= FullSpeed && duty_b <= FullSpeed)
    else $error("duty above full speed");

  a_one_at_base: assert property (@(posedge clk) disable iff (rst)
    duty_a == speed || duty_b == speed)
    else $error("neither duty at base speed");

  a_run_bridge: assert property (@(posedge clk) disable iff (rst)
    motor_enable == (bridge != BridgeStop))
    else $error("motor run flag disagrees with bridge");

  a_straight: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(advance) && $past(code) == CodeStraight
    |-> duty_a == duty_b && left_pct == PctFull && right_pct == PctFull)
    else $error("straighten left steering in place");
`endif

endmodule

`default_nettype wire

/* rtl/dcd_scale.sv */
`timescale 1ns / 1ps
`default_nettype none

module dcd_scale (
  input  wire logic [dcd_pkg::TensW-1:0] speed_tens,
  input  wire logic [dcd_pkg::PctW-1:0]  pct,
  output logic      [dcd_pkg::DutyW-1:0] duty
);
  import dcd_pkg::*;

  logic [ProdW-1:0] prod;
  logic [WideW-1:0] wide;

  // tens * pct / 10, divide by reciprocal, exact over the product range
  assign prod = ProdW'(speed_tens) * ProdW'(pct);
  assign wide = WideW'(prod) * WideW'(RecipTen);
  assign duty = wide[RecipSh +: DutyW];

endmodule

`default_nettype wire

/* verif/tb_drive_command_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_drive_command_decoder_unit;
  import dcd_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int TailCycles = 10;

  typedef struct packed {
    logic [DutyW-1:0]   duty_a;
    logic [DutyW-1:0]   duty_b;
    logic [BridgeW-1:0] bridge_bits;
    logic               motor_enable;
    logic [DimW-1:0]    dim_duty;
    logic               dim_enable;
    logic               buzzer_on;
    logic               lamp_on;
  } drive_outputs_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CodeW-1:0]  command_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DutyW-1:0]  duty_a;
  logic [DutyW-1:0]  duty_b;
  logic [BridgeW-1:0] bridge_bits;
  logic              motor_enable;
  logic [DimW-1:0]   dim_duty;
  logic              dim_enable;
  logic              buzzer_on;
  logic              lamp_on;

  drive_command_decoder_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command_code (command_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty_a       (duty_a),
    .duty_b       (duty_b),
    .bridge_bits  (bridge_bits),
    .motor_enable (motor_enable),
    .dim_duty     (dim_duty),
    .dim_enable   (dim_enable),
    .buzzer_on    (buzzer_on),
    .lamp_on      (lamp_on)
  );

  // mirrored drive state
  logic [DutyW-1:0] m_base;
  logic [PctW-1:0]  m_left_pct;
  logic [PctW-1:0]  m_right_pct;
  logic [DutyW-1:0] m_duty_a;
  logic [DutyW-1:0] m_duty_b;
  bridge_t          m_bridge;
  logic             m_run;
  logic [DimW-1:0]  m_dim_duty;
  logic             m_dim_en;
  logic             m_buzzer;
  logic             m_lamp;

  drive_outputs_t pending_outputs[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int items_sent = 0;
  int ignored_codes = 0;
  int results_checked = 0;
  int error_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [DutyW-1:0] scale_duty(input logic [DutyW-1:0] speed,
                                                  input logic [PctW-1:0] pct);
    int unsigned prod;
    prod = speed;
    prod = (prod * pct) / 100;
    return prod[DutyW-1:0];
  endfunction

  function automatic void reset_drive_model();
    m_base      = FullSpeed;
    m_left_pct  = PctFull;
    m_right_pct = PctFull;
    m_duty_a    = FullSpeed;
    m_duty_b    = FullSpeed;
    m_bridge    = BridgeStop;
    m_run       = 1'b0;
    m_dim_duty  = DimReset;
    m_dim_en    = 1'b0;
    m_buzzer    = 1'b0;
    m_lamp      = 1'b0;
  endfunction

  function automatic void straighten_drive();
    m_duty_a    = m_base;
    m_duty_b    = m_base;
    m_left_pct  = PctFull;
    m_right_pct = PctFull;
  endfunction

  // Apply one command to the mirrored state, queue the resulting outputs and
  // report whether the code was recognised.
  function automatic bit apply_drive_command(input logic [CodeW-1:0] code);
    int unsigned v;
    bit known;
    drive_outputs_t o;
    known = 1'b1;
    v = code;
    if (code >= CodeLeftLo && code <= CodeLeftHi) begin
      m_left_pct = 7'(v - LeftBase);
      m_duty_a   = m_base;
      m_duty_b   = scale_duty(m_base, m_left_pct);
    end else if (code >= CodeRightLo && code <= CodeRightHi) begin
      m_right_pct = 7'(RightBase - v);
      m_duty_b    = m_base;
      m_duty_a    = scale_duty(m_base, m_right_pct);
    end else if (code >= CodeDimLo && code <= CodeDimHi) begin
      m_dim_duty = 8'((v - DimBase) * 3);
    end else if (code >= CodeSpeedLo && code <= CodeSpeedHi) begin
      m_base = 10'((v - SpeedBase) * 10);
      if (m_duty_a > m_duty_b) begin
        m_duty_a = m_base;
        m_duty_b = scale_duty(m_base, m_left_pct);
      end else if (m_duty_b > m_duty_a) begin
        m_duty_b = m_base;
        m_duty_a = scale_duty(m_base, m_right_pct);
      end else begin
        m_duty_a = m_base;
        m_duty_b = m_base;
      end
    end else begin
      case (code)
        CodeStop: begin
          m_bridge = BridgeStop;
          m_run    = 1'b0;
        end
        CodeForward: begin
          m_bridge = BridgeForward;
          m_run    = 1'b1;
        end
        CodeBack: begin
          m_bridge = BridgeBack;
          m_run    = 1'b1;
        end
        CodeLeftRot: begin
          m_bridge = BridgeLeft;
          m_run    = 1'b1;
        end
        CodeRightRot: begin
          m_bridge = BridgeRight;
          m_run    = 1'b1;
        end
        CodeStraight: straighten_drive();
        CodeFullSpeed: begin
          m_base = FullSpeed;
          straighten_drive();
        end
        CodeBuzzOff: m_buzzer = 1'b0;
        CodeBuzzOn:  m_buzzer = 1'b1;
        CodeLampOff: m_lamp = 1'b0;
        CodeLampOn:  m_lamp = 1'b1;
        CodeDimOff:  m_dim_en = 1'b0;
        CodeDimOn:   m_dim_en = 1'b1;
        default:     known = 1'b0;
      endcase
    end
    o.duty_a       = m_duty_a;
    o.duty_b       = m_duty_b;
    o.bridge_bits  = m_bridge;
    o.motor_enable = m_run;
    o.dim_duty     = m_dim_duty;
    o.dim_enable   = m_dim_en;
    o.buzzer_on    = m_buzzer;
    o.lamp_on      = m_lamp;
    pending_outputs.push_back(o);
    return known;
  endfunction

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < sink_stall_pct);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    drive_outputs_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual duty_a %0d duty_b %0d",
                 $time, duty_a, duty_b);
        error_count++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("duty_a", want.duty_a, duty_a);
        check_field("duty_b", want.duty_b, duty_b);
        check_field("bridge_bits", want.bridge_bits, bridge_bits);
        check_field("motor_enable", want.motor_enable, motor_enable);
        check_field("dim_duty", want.dim_duty, dim_duty);
        check_field("dim_enable", want.dim_enable, dim_enable);
        check_field("buzzer_on", want.buzzer_on, buzzer_on);
        check_field("lamp_on", want.lamp_on, lamp_on);
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
    $display("drive_command_decoder_unit test failed");
    $finish;
  end

  // Hold valid until the transfer, then predict. Returns whether the code was recognised.
  task automatic send_command(input logic [CodeW-1:0] code, output bit known);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    known = apply_drive_command(code);
    items_sent++;
    if (!known) ignored_codes++;
  endtask

  task automatic send_list(input logic [CodeW-1:0] codes[]);
    bit known;
    foreach (codes[i]) send_command(codes[i], known);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CodeW-1:0] random_drive_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return CodeW'($urandom_range(0, 65535));
    if (r < 18) begin
      case ($urandom_range(0, 3))
        0: return CodeW'($urandom_range(CodeRightHi + 1, CodeDimLo - 1));
        1: return CodeW'($urandom_range(CodeDimHi + 1, CodeSpeedLo - 1));
        2: return CodeW'($urandom_range(CodeSpeedHi + 1, CodeStop - 1));
        default: return CodeW'($urandom_range(CodeRightRot + 1, CodeStraight - 1));
      endcase
    end
    if (r < 40) return CodeW'($urandom_range(CodeLeftLo, CodeRightHi));
    if (r < 50) return CodeW'($urandom_range(CodeDimLo, CodeDimHi));
    if (r < 66) return CodeW'($urandom_range(CodeSpeedLo, CodeSpeedHi));
    if (r < 80) return CodeW'($urandom_range(CodeStop, CodeRightRot));
    if (r < 86) return ($urandom_range(0, 1) != 0) ? CodeFullSpeed : CodeStraight;
    case ($urandom_range(0, 5))
      0: return CodeBuzzOff;
      1: return CodeBuzzOn;
      2: return CodeLampOff;
      3: return CodeLampOn;
      4: return CodeDimOff;
      default: return CodeDimOn;
    endcase
  endfunction

  task automatic test_unknown_codes();
    send_list('{16'd0, 16'hFFFF, CodeRightHi + 16'd4, CodeDimHi + 16'd1,
                CodeSpeedLo - 16'd1});
  endtask

  task automatic test_steering_and_speed();
    // left steer then speed (a > b), right steer then speed (b > a), equal duties
    send_list('{CodeLeftLo, CodeSpeedLo, CodeLeftHi, CodeRightLo, CodeSpeedHi,
                CodeRightHi, CodeStraight, CodeSpeedLo + 16'd20, CodeFullSpeed});
  endtask

  task automatic test_bridge_commands();
    send_list('{CodeForward, CodeBack, CodeLeftRot, CodeRightRot, CodeStop});
  endtask

  task automatic test_indicators();
    send_list('{CodeDimLo, CodeDimHi, CodeBuzzOn, CodeBuzzOff, CodeLampOn, CodeLampOff,
                CodeDimOn, CodeDimOff});
  endtask

  task automatic test_random_phase(input int src_pct, input int sink_pct, input int count);
    bit known;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (count) send_command(random_drive_code(), known);
    drain_outputs();
  endtask

  initial begin
    reset_drive_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct   = 23;
    sink_stall_pct = 58;
    test_unknown_codes();
    test_steering_and_speed();
    test_bridge_commands();
    test_indicators();
    drain_outputs();

    test_random_phase(23, 58, 400);
    test_random_phase(58, 23, 400);
    test_random_phase(0, 0, 400);

    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d commands (%0d unrecognised), checked %0d output transfers.",
             items_sent, ignored_codes, results_checked);
    $display("Covered steering, speed, dimming, bridge, indicator and gap codes.");
    if (error_count == 0 && pending_outputs.size() == 0) begin
      $display("drive_command_decoder_unit test passed");
    end else begin
      $display("%0t: %0d mismatches, %0d transfers outstanding", $time, error_count,
               pending_outputs.size());
      $display("drive_command_decoder_unit test failed");
    end
    $finish;
  end

endmodule
